// ----- design/gbts_pkg.sv -----
// Shared constants, codes and inter-module structs for the gap buffer text store.
// No dependencies; imported by gap_buffer_text_store_core and gbts_seq.
package gbts_pkg;

    localparam int BUF_SIZE = 8192;
    localparam int MAX_RUN  = 16;
    localparam int ADDR_W   = $clog2(BUF_SIZE);
    localparam int LEN_W    = 14;
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_PAST_END = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_MOVE,
        ST_WB,
        ST_FIN,
        ST_RESP,
        ST_READ,
        ST_RDRAIN
    } t_state;

    // Memory port request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // One result transfer
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] read_byte;
        t_status           status;
        logic              last;
        logic [LEN_W-1:0]  text_length;
    } t_result;

endpackage

// ----- design/gap_buffer_text_store_core.sv -----
// Top level of the gap buffer text store: sequencer, byte memory, result register.
// Depends on gbts_pkg, gbts_ram and gbts_seq.

// The text lives in one 8192 x 8 memory as a front span at the bottom, a free
// gap, and a back span at the top. Raise start with an operation when busy is
// low; the item is taken at that edge. Results come out on the o_ ports for
// exactly one cycle each, marked by o_strobe, and cannot be held off: the
// receiver must take every transfer as it appears. Insert, delete and clear
// give one result; a read gives one result per byte (at most MAX_RUN) with
// o_last on the final one, or a single result when empty or out of range.
// Insert and delete first move the gap to the position through the single
// memory read port, one byte copied per cycle, unless the gap is already
// there; a read of n bytes strobes them on consecutive cycles.
// The next item may be started in the cycle the final result is strobed.
// Memory contents are not cleared at reset or by clear; only bytes that were
// written are ever returned.
module gap_buffer_text_store_core
    import gbts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [LEN_W-1:0]  i_position,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_run_length,
    output logic              o_strobe,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic [STAT_W-1:0] o_status,
    output logic              o_last,
    output logic [LEN_W-1:0]  o_text_length
);

    t_mem_req          w_mem;
    t_result           w_res;
    logic [BYTE_W-1:0] w_rdata;
    logic              w_busy;

    logic              r_strobe;
    logic [BYTE_W-1:0] r_read_byte;
    t_status           r_status;
    logic              r_last;
    logic [LEN_W-1:0]  r_text_length;

    gbts_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_op         (t_op'(i_op)),
        .i_position   (i_position),
        .i_data_byte  (i_data_byte),
        .i_run_length (i_run_length),
        .i_rdata      (w_rdata),
        .o_busy       (w_busy),
        .o_mem        (w_mem),
        .o_res        (w_res)
    );

    gbts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_SIZE)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Output register: every result transfer is held for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_byte   <= w_res.read_byte;
        r_status      <= w_res.status;
        r_last        <= w_res.last;
        r_text_length <= w_res.text_length;
    end

    assign busy          = w_busy;
    assign o_strobe      = r_strobe;
    assign o_read_byte   = r_read_byte;
    assign o_status      = r_status;
    assign o_last        = r_last;
    assign o_text_length = r_text_length;

    // An accepted item always holds the block busy the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // Error results are single transfers with no data
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != STAT_OK) |-> (o_last && o_read_byte == '0))
        else $error("error result not a single empty transfer");

    // Results and memory writes only come from work in progress
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> busy)
        else $error("result produced while idle");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem.we |-> busy)
        else $error("memory write while idle");

endmodule

// ----- design/gbts_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/gbts_seq.sv -----
// Operation sequencer: span lengths, gap moves, run reads and memory requests.
// Depends on gbts_pkg; drives one gbts_ram through t_mem_req.
module gbts_seq
    import gbts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_op               i_op,
    input  logic [LEN_W-1:0]  i_position,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [LEN_W-1:0]  i_run_length,
    input  logic [BYTE_W-1:0] i_rdata,
    output logic              o_busy,
    output t_mem_req          o_mem,
    output t_result           o_res
);

    t_state            r_state,  n_state;
    t_op               r_op,     n_op;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_pos,    n_pos;
    logic [BYTE_W-1:0] r_data,   n_data;
    logic [LEN_W-1:0]  r_run,    n_run;
    logic [LEN_W-1:0]  r_front,  n_front;
    logic [LEN_W-1:0]  r_back,   n_back;
    logic [LEN_W-1:0]  r_gap,    n_gap;
    logic [LEN_W-1:0]  r_cnt,    n_cnt;
    logic [ADDR_W-1:0] r_src,    n_src;
    logic [ADDR_W-1:0] r_dst,    n_dst;
    logic              r_fwd,    n_fwd;
    logic              r_wpend,  n_wpend;
    logic [ADDR_W-1:0] r_wpaddr, n_wpaddr;
    logic              r_rpend,  n_rpend;
    logic              r_rplast, n_rplast;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  avail;
    logic              pos_bad;
    logic              fwd;
    logic [LEN_W-1:0]  shift;
    logic [LEN_W-1:0]  src_full;
    logic [LEN_W-1:0]  dst_full;
    logic [LEN_W-1:0]  run_sat;
    logic [LEN_W-1:0]  rd_n;
    logic [LEN_W-1:0]  rd_addr_full;

    assign len     = r_front + r_back;
    assign avail   = len - r_pos;
    assign pos_bad = r_pos > len;

    // After the move the back span is always len - pos, in either direction
    assign fwd      = r_pos > r_front;
    assign shift    = fwd ? (r_pos - r_front) : (r_front - r_pos);
    assign src_full = fwd ? (r_front + r_gap) : (r_front - LEN_W'(1));
    assign dst_full = fwd ? r_front : (r_front - LEN_W'(1) + r_gap);

    assign run_sat = (r_run > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : r_run;
    assign rd_n    = (run_sat > avail) ? avail : run_sat;

    assign rd_addr_full = (r_pos < r_front) ? r_pos : (r_pos + r_gap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_gap   <= LEN_W'(BUF_SIZE);
            r_wpend <= 1'b0;
            r_rpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_gap   <= n_gap;
            r_wpend <= n_wpend;
            r_rpend <= n_rpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_data   <= n_data;
        r_run    <= n_run;
        r_cnt    <= n_cnt;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_fwd    <= n_fwd;
        r_wpaddr <= n_wpaddr;
        r_rplast <= n_rplast;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_status = r_status;
        n_pos    = r_pos;
        n_data   = r_data;
        n_run    = r_run;
        n_front  = r_front;
        n_back   = r_back;
        n_gap    = r_gap;
        n_cnt    = r_cnt;
        n_src    = r_src;
        n_dst    = r_dst;
        n_fwd    = r_fwd;
        n_wpend  = 1'b0;
        n_wpaddr = r_wpaddr;
        n_rpend  = 1'b0;
        n_rplast = r_rplast;

        // copy write lands in the cycle after its read
        o_mem.we    = r_wpend;
        o_mem.waddr = r_wpaddr;
        o_mem.wdata = i_rdata;
        o_mem.raddr = r_src;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_pos   = i_position;
                    n_data  = i_data_byte;
                    n_run   = i_run_length;
                    n_state = ST_PLAN;
                end
            end
            ST_PLAN: begin
                n_status = STAT_OK;
                n_state  = ST_RESP;
                unique case (r_op) inside
                    OP_INSERT, OP_DELETE: begin
                        if (pos_bad) begin
                            n_status = STAT_RANGE;
                        end else if (r_op == OP_INSERT && r_gap == '0) begin
                            n_status = STAT_FULL;
                        end else if (r_op == OP_DELETE && r_run > avail) begin
                            n_status = STAT_PAST_END;
                        end else begin
                            n_front = r_pos;
                            n_back  = avail;
                            n_cnt   = shift;
                            n_src   = src_full[ADDR_W-1:0];
                            n_dst   = dst_full[ADDR_W-1:0];
                            n_fwd   = fwd;
                            n_state = (shift == '0) ? ST_FIN : ST_MOVE;
                        end
                    end
                    OP_READ: begin
                        if (pos_bad) begin
                            n_status = STAT_RANGE;
                        end else if (rd_n != '0) begin
                            n_cnt   = rd_n;
                            n_state = ST_READ;
                        end
                    end
                    OP_CLEAR: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_MOVE: begin
                o_mem.raddr = r_src;
                n_wpend     = 1'b1;
                n_wpaddr    = r_dst;
                n_src       = r_fwd ? (r_src + ADDR_W'(1)) : (r_src - ADDR_W'(1));
                n_dst       = r_fwd ? (r_dst + ADDR_W'(1)) : (r_dst - ADDR_W'(1));
                n_cnt       = r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                unique case (r_op)
                    OP_INSERT: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_front[ADDR_W-1:0];
                        o_mem.wdata = r_data;
                        n_front     = r_front + LEN_W'(1);
                        n_gap       = r_gap - LEN_W'(1);
                    end
                    OP_DELETE: begin
                        n_gap  = r_gap + r_run;
                        n_back = r_back - r_run;
                    end
                    OP_CLEAR: begin
                        n_front = '0;
                        n_back  = '0;
                        n_gap   = LEN_W'(BUF_SIZE);
                    end
                    OP_READ: begin
                    end
                endcase
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            ST_READ: begin
                o_mem.raddr = rd_addr_full[ADDR_W-1:0];
                n_rpend     = 1'b1;
                n_rplast    = (r_cnt == LEN_W'(1));
                n_pos       = r_pos + LEN_W'(1);
                n_cnt       = r_cnt - LEN_W'(1);
                if (r_cnt == LEN_W'(1)) begin
                    n_state = ST_RDRAIN;
                end
            end
            ST_RDRAIN: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Results: read data as it returns, or the single status result
    always_comb begin
        o_res.valid       = 1'b0;
        o_res.read_byte   = '0;
        o_res.status      = STAT_OK;
        o_res.last        = 1'b1;
        o_res.text_length = len;
        if (r_rpend) begin
            o_res.valid     = 1'b1;
            o_res.read_byte = i_rdata;
            o_res.last      = r_rplast;
        end else if (r_state == ST_RESP) begin
            o_res.valid  = 1'b1;
            o_res.status = r_status;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for gap_buffer_text_store_core: command-style driver,
// strobe monitor and a byte-queue text predictor. Depends on gbts_pkg and the block RTL.
`timescale 1ns / 1ps

module testbench;
    import gbts_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int CYCLE_CAP  = 1500000;   // the run fails with TB_ERROR once this is reached
    localparam int TAIL_WAIT  = 24;        // quiet cycles after the last result

    // One command as the sender holds it
    typedef struct {
        t_op               op;
        logic [LEN_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  run;
        bit                drain;  // hold off until every awaited result is in
    } t_text_cmd;

    // One result transfer as the predictor expects it
    typedef struct {
        logic [BYTE_W-1:0] rd;
        t_status           st;
        logic              lst;
        logic [LEN_W-1:0]  len;
    } t_text_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op = '0;
    logic [LEN_W-1:0]  i_position = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic [LEN_W-1:0]  i_run_length = '0;
    logic              o_strobe;
    logic [BYTE_W-1:0] o_read_byte;
    logic [STAT_W-1:0] o_status;
    logic              o_last;
    logic [LEN_W-1:0]  o_text_length;

    gap_buffer_text_store_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_data_byte   (i_data_byte),
        .i_run_length  (i_run_length),
        .o_strobe      (o_strobe),
        .o_read_byte   (o_read_byte),
        .o_status      (o_status),
        .o_last        (o_last),
        .o_text_length (o_text_length)
    );

    // Predictor state: the logical text, gap layout does not matter to the outside
    logic [BYTE_W-1:0] text_model[$];
    t_text_result      awaited_results[$];
    t_text_cmd         cmd_queue[$];

    int  queued_cnt = 0;   // commands handed to the driver
    int  sent_cnt   = 0;   // commands put on the bus
    int  taken_cnt  = 0;   // commands accepted by the block
    int  err_cnt    = 0;
    int  burst_left = 0;
    int  cycle_cnt  = 0;
    bit  idle_on    = 1'b1;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Expected result, text length taken after the edit
    function automatic void post_result(logic [BYTE_W-1:0] rd, t_status st, logic lst);
        t_text_result r;
        r.rd  = rd;
        r.st  = st;
        r.lst = lst;
        r.len = LEN_W'(text_model.size());
        awaited_results.push_back(r);
    endfunction

    // Applies one accepted command to the text and queues its results
    function automatic void edit_text(t_text_cmd c);
        int len;
        int pos;
        int n;
        len = text_model.size();
        pos = int'(c.pos);
        case (c.op)
            OP_INSERT: begin
                if (pos > len) begin
                    post_result('0, STAT_RANGE, 1'b1);
                end else if (len == BUF_SIZE) begin
                    post_result('0, STAT_FULL, 1'b1);
                end else begin
                    text_model.insert(pos, c.data);
                    post_result('0, STAT_OK, 1'b1);
                end
            end
            OP_DELETE: begin
                if (pos > len) begin
                    post_result('0, STAT_RANGE, 1'b1);
                end else if (int'(c.run) > len - pos) begin
                    post_result('0, STAT_PAST_END, 1'b1);
                end else begin
                    repeat (int'(c.run)) text_model.delete(pos);
                    post_result('0, STAT_OK, 1'b1);
                end
            end
            OP_READ: begin
                if (pos > len) begin
                    post_result('0, STAT_RANGE, 1'b1);
                end else begin
                    n = int'(c.run);
                    if (n > MAX_RUN) n = MAX_RUN;
                    if (n > len - pos) n = len - pos;
                    if (n == 0) begin
                        post_result('0, STAT_OK, 1'b1);
                    end
                    for (int i = 0; i < n; i++) begin
                        post_result(text_model[pos + i], STAT_OK, i == n - 1);
                    end
                end
            end
            default: begin
                text_model.delete();
                post_result('0, STAT_OK, 1'b1);
            end
        endcase
    endfunction

    // Driver: inputs change on the falling edge. A command stays on the bus
    // until the transfer happens; gaps only open between commands.
    always @(negedge i_clk) begin
        t_text_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (sent_cnt != taken_cnt) begin
            // still waiting for busy to drop, keep everything as it is
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            start <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain && awaited_results.size() != 0)) begin
            c = cmd_queue.pop_front();
            i_op         <= c.op;
            i_position   <= c.pos;
            i_data_byte  <= c.data;
            i_run_length <= c.run;
            start        <= 1'b1;
            sent_cnt     <= sent_cnt + 1;
            if (idle_on && $urandom_range(4) == 0) begin
                burst_left <= $urandom_range(1, 14);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: results are checked before a command taken at the same edge
    // is predicted, since the older item's result belongs first.
    always @(posedge i_clk) begin
        t_text_cmd    c;
        t_text_result r;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing awaited: byte %0d status %0d len %0d",
                           o_read_byte, o_status, o_text_length);
                    err_cnt++;
                end else begin
                    r = awaited_results.pop_front();
                    if (o_read_byte !== r.rd) begin
                        $error("read_byte: expected %0d, got %0d", r.rd, o_read_byte);
                        err_cnt++;
                    end
                    if (o_status !== r.st) begin
                        $error("status: expected %0d, got %0d", r.st, o_status);
                        err_cnt++;
                    end
                    if (o_last !== r.lst) begin
                        $error("last: expected %0d, got %0d", r.lst, o_last);
                        err_cnt++;
                    end
                    if (o_text_length !== r.len) begin
                        $error("text_length: expected %0d, got %0d", r.len, o_text_length);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                c.op   = t_op'(i_op);
                c.pos  = i_position;
                c.data = i_data_byte;
                c.run  = i_run_length;
                c.drain = 1'b0;
                edit_text(c);
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    // Hands one command to the driver and returns once the block took it,
    // so the generator sees the text length after that edit.
    task automatic send(t_op op, int pos, int data, int run, bit drain = 1'b0);
        t_text_cmd c;
        c.op    = op;
        c.pos   = LEN_W'(pos);
        c.data  = BYTE_W'(data);
        c.run   = LEN_W'(run);
        c.drain = drain;
        cmd_queue.push_back(c);
        queued_cnt++;
        while (taken_cnt < queued_cnt) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // Mostly well-formed edits on a short text, with some out-of-range noise
    task automatic random_cmd();
        int len;
        int sel;
        int pos;
        int room;
        len = text_model.size();
        sel = $urandom_range(99);
        if (sel < 6) begin
            send(t_op'($urandom_range(3)), $urandom_range(16383), $urandom_range(255),
                 $urandom_range(16383));
        end else if (sel < 9) begin
            send(OP_CLEAR, $urandom_range(16383), $urandom_range(255), $urandom_range(16383));
        end else if (sel < 50 && len < 300) begin
            if ($urandom_range(9) == 0) pos = $urandom_range(len + 1, 16383);
            else pos = $urandom_range(len);
            send(OP_INSERT, pos, $urandom_range(255), $urandom_range(16383),
                 $urandom_range(19) == 0);
        end else if (sel < 75) begin
            pos  = $urandom_range(len);
            room = len - pos;
            if ($urandom_range(9) == 0) begin
                send(OP_DELETE, pos, $urandom_range(255), room + 1 + $urandom_range(60));
            end else begin
                send(OP_DELETE, pos, $urandom_range(255),
                     $urandom_range(room > 40 ? 40 : room));
            end
        end else begin
            pos = ($urandom_range(15) == 0) ? $urandom_range(len + 1, 16383)
                                            : $urandom_range(len);
            send(OP_READ, pos, $urandom_range(255),
                 ($urandom_range(7) == 0) ? $urandom_range(16383) : $urandom_range(20));
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Directed: empty store, errors, both ends of the fields
        send(OP_READ,   0,     0,    5);      // empty read
        send(OP_READ,   1,     0,    1);      // read past end
        send(OP_DELETE, 0,     0,    0);      // zero-length delete on empty text
        send(OP_DELETE, 0,     0,    1);      // delete past end
        send(OP_INSERT, 1,     8'h11, 0);     // insert past end
        send(OP_INSERT, 0,     8'h00, 16383);
        send(OP_INSERT, 1,     8'hFF, 0);
        send(OP_INSERT, 0,     8'hA5, 0);     // gap moves back to the front
        send(OP_INSERT, 3,     8'h5A, 0);     // and forward again
        send(OP_INSERT, 2,     8'h3C, 0, 1'b1);
        send(OP_READ,   0,     0,    16383);  // run clipped at the text end
        send(OP_READ,   5,     0,    3);      // read at the very end: empty
        send(OP_READ,   16383, 8'hFF, 16383); // far out of range
        send(OP_DELETE, 6,     0,    0);
        send(OP_DELETE, 1,     0,    5);
        send(OP_DELETE, 1,     0,    2);
        send(OP_DELETE, 3,     0,    0);
        send(OP_READ,   0,     0,    0);      // zero-length read
        send(OP_READ,   0,     0,    16);
        send(OP_CLEAR,  16383, 8'hFF, 16383);
        send(OP_READ,   0,     0,    1);
        for (int i = 0; i < 20; i++) send(OP_INSERT, i, $urandom_range(255), 0);
        send(OP_READ,   2,     0,    16);
        send(OP_READ,   1,     0,    17);     // clipped at MAX_RUN

        // Random part, with stretches with and without idling
        for (int i = 0; i < 210; i++) begin
            idle_on = (i < 90) || (i >= 120 && i < 160);
            random_cmd();
        end

        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
